/* rtl/psd_pkg.sv */
package psd_pkg;

  // coordinate and derived widths
  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DOT_W   = PROD_W + 1;
  localparam int LEN_W   = PROD_W;
  localparam int HALF_W  = LEN_W / 2;
  localparam int NUM_W   = 2 * LEN_W;
  localparam int DIST_W  = COORD_W + 1;
  localparam int ACC_W   = NUM_W + 2;
  localparam int Q_W     = DIST_W + LEN_W;

  // queue depths
  localparam int MID_DEPTH = 8;
  localparam int MID_AW    = $clog2(MID_DEPTH);
  localparam int OUT_DEPTH = 32;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);

  typedef enum logic [1:0] {
    PART_INTERIOR = 2'd0,
    PART_START    = 2'd1,
    PART_END      = 2'd2
  } part_t;

  // one root job between front and back
  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [LEN_W-1:0] den;
    part_t            part;
  } work_t;

  // one finished result
  typedef struct packed {
    logic [DIST_W-1:0] seg_dist;
    part_t             part;
  } res_t;

endpackage

/* rtl/psd_front.sv */
module psd_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic signed [psd_pkg::COORD_W-1:0] start_x,
  input  logic signed [psd_pkg::COORD_W-1:0] start_y,
  input  logic signed [psd_pkg::COORD_W-1:0] end_x,
  input  logic signed [psd_pkg::COORD_W-1:0] end_y,
  input  logic signed [psd_pkg::COORD_W-1:0] point_x,
  input  logic signed [psd_pkg::COORD_W-1:0] point_y,
  output logic                               out_valid,
  output psd_pkg::work_t                     out_work
);

  logic [4:0] v_r;

  // stage 1: differences
  logic signed [psd_pkg::DIFF_W-1:0] dx_r, dy_r, rx_r, ry_r, fx_r, fy_r;
  // stage 2: products
  logic signed [psd_pkg::PROD_W-1:0] dxx_r, dyy_r, rxdx_r, rydy_r, rydx_r, rxdy_r;
  logic signed [psd_pkg::PROD_W-1:0] rxx_r, ryy_r, fxx_r, fyy_r;
  // stage 3: sums
  logic        [psd_pkg::LEN_W-1:0] len2_r, cabs_r, sr_r, sf_r;
  logic signed [psd_pkg::DOT_W-1:0] dot_r;
  // stage 4: classify and split square
  psd_pkg::part_t                     part_r;
  logic        [psd_pkg::LEN_W-1:0]   den_r, ep_r;
  logic        [2*psd_pkg::HALF_W-1:0] hh_r, hl_r, ll_r;
  // stage 5: job
  psd_pkg::work_t work_r;

  logic signed [psd_pkg::DOT_W-1:0] dot_nxt, c_nxt;
  logic        [psd_pkg::LEN_W-1:0] cabs_nxt;
  psd_pkg::part_t                    part_nxt;
  logic        [psd_pkg::HALF_W-1:0] h_c, l_c;
  logic        [psd_pkg::NUM_W-1:0] sq_c;

  // valid shift line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[3:0], in_valid};
    end
  end

  // sums and absolute cross product
  always_comb begin
    dot_nxt  = psd_pkg::DOT_W'(rxdx_r) + psd_pkg::DOT_W'(rydy_r);
    c_nxt    = psd_pkg::DOT_W'(rydx_r) - psd_pkg::DOT_W'(rxdy_r);
    cabs_nxt = c_nxt[psd_pkg::DOT_W-1] ? psd_pkg::LEN_W'(-c_nxt)
                                       : psd_pkg::LEN_W'(c_nxt);
  end

  // projection test without division
  always_comb begin
    if ((len2_r == '0) || dot_r[psd_pkg::DOT_W-1]) begin
      part_nxt = psd_pkg::PART_START;
    end else if (dot_r > $signed({1'b0, len2_r})) begin
      part_nxt = psd_pkg::PART_END;
    end else begin
      part_nxt = psd_pkg::PART_INTERIOR;
    end
    h_c = cabs_r[psd_pkg::LEN_W-1:psd_pkg::HALF_W];
    l_c = cabs_r[psd_pkg::HALF_W-1:0];
  end

  // square of the cross product from partial products
  assign sq_c = (psd_pkg::NUM_W'(hh_r) << (2 * psd_pkg::HALF_W))
              + (psd_pkg::NUM_W'(hl_r) << (psd_pkg::HALF_W + 1))
              + psd_pkg::NUM_W'(ll_r);

  // datapath stages
  always_ff @(posedge clk) begin
    dx_r <= psd_pkg::DIFF_W'(end_x)   - psd_pkg::DIFF_W'(start_x);
    dy_r <= psd_pkg::DIFF_W'(end_y)   - psd_pkg::DIFF_W'(start_y);
    rx_r <= psd_pkg::DIFF_W'(point_x) - psd_pkg::DIFF_W'(start_x);
    ry_r <= psd_pkg::DIFF_W'(point_y) - psd_pkg::DIFF_W'(start_y);
    fx_r <= psd_pkg::DIFF_W'(point_x) - psd_pkg::DIFF_W'(end_x);
    fy_r <= psd_pkg::DIFF_W'(point_y) - psd_pkg::DIFF_W'(end_y);

    dxx_r  <= dx_r * dx_r;
    dyy_r  <= dy_r * dy_r;
    rxdx_r <= rx_r * dx_r;
    rydy_r <= ry_r * dy_r;
    rydx_r <= ry_r * dx_r;
    rxdy_r <= rx_r * dy_r;
    rxx_r  <= rx_r * rx_r;
    ryy_r  <= ry_r * ry_r;
    fxx_r  <= fx_r * fx_r;
    fyy_r  <= fy_r * fy_r;

    len2_r <= $unsigned(dxx_r) + $unsigned(dyy_r);
    dot_r  <= dot_nxt;
    cabs_r <= cabs_nxt;
    sr_r   <= $unsigned(rxx_r) + $unsigned(ryy_r);
    sf_r   <= $unsigned(fxx_r) + $unsigned(fyy_r);

    part_r <= part_nxt;
    den_r  <= (part_nxt == psd_pkg::PART_INTERIOR) ? len2_r : psd_pkg::LEN_W'(1);
    ep_r   <= (part_nxt == psd_pkg::PART_START) ? sr_r : sf_r;
    hh_r   <= h_c * h_c;
    hl_r   <= h_c * l_c;
    ll_r   <= l_c * l_c;

    work_r.part <= part_r;
    work_r.den  <= den_r;
    work_r.num  <= (part_r == psd_pkg::PART_INTERIOR) ? sq_c : psd_pkg::NUM_W'(ep_r);
  end

  assign out_valid = v_r[4];
  assign out_work  = work_r;

endmodule

/* rtl/psd_root.sv */
module psd_root (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  psd_pkg::work_t              in_work,
  output logic                        out_valid,
  output psd_pkg::res_t               out_res
);

  localparam int STAGES = psd_pkg::DIST_W;

  logic [STAGES:0]                v_r;
  logic [psd_pkg::NUM_W-1:0]     num_r [STAGES+1];
  logic [psd_pkg::LEN_W-1:0]     den_r [STAGES+1];
  logic [psd_pkg::NUM_W-1:0]     p_r   [STAGES+1];
  logic [psd_pkg::Q_W-1:0]       qd_r  [STAGES+1];
  logic [psd_pkg::DIST_W-1:0]    q_r   [STAGES+1];
  psd_pkg::part_t                part_r [STAGES+1];

  // stage 0 takes the job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    num_r[0]  <= in_work.num;
    den_r[0]  <= in_work.den;
    part_r[0] <= in_work.part;
    p_r[0]    <= '0;
    qd_r[0]   <= '0;
    q_r[0]    <= '0;
  end

  // one result bit per stage, most significant first
  for (genvar i = 0; i < STAGES; i++) begin : g_bit
    localparam int B = STAGES - 1 - i;
    logic [psd_pkg::ACC_W-1:0] trial_c;
    logic                      take_c;

    // (q + 2^b)^2 * den = p + qd * 2^(b+1) + den * 2^(2b)
    always_comb begin
      trial_c = psd_pkg::ACC_W'(p_r[i])
              + (psd_pkg::ACC_W'(qd_r[i]) << (B + 1))
              + (psd_pkg::ACC_W'(den_r[i]) << (2 * B));
      take_c  = trial_c <= psd_pkg::ACC_W'(num_r[i]);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      num_r[i+1]  <= num_r[i];
      den_r[i+1]  <= den_r[i];
      part_r[i+1] <= part_r[i];
      if (take_c) begin
        p_r[i+1]  <= psd_pkg::NUM_W'(trial_c);
        qd_r[i+1] <= qd_r[i] + (psd_pkg::Q_W'(den_r[i]) << B);
        q_r[i+1]  <= q_r[i] | (psd_pkg::DIST_W'(1) << B);
      end else begin
        p_r[i+1]  <= p_r[i];
        qd_r[i+1] <= qd_r[i];
        q_r[i+1]  <= q_r[i];
      end
    end
  end

  assign out_valid        = v_r[STAGES];
  assign out_res.seg_dist = q_r[STAGES];
  assign out_res.part     = part_r[STAGES];

endmodule

/* rtl/point_to_segment_distance.sv */
// point to segment distance, streaming
// input side is a queue: drive the six coordinates (signed Q8.8) with push;
// a request is taken on a rising edge with push high and full low.
// result side is a queue: while empty is low the oldest result is on
// out_seg_distance (unsigned Q9.8, truncated) and out_nearest_part
// (interior, start or end); pop on a rising edge with empty low takes it.
// a result passes 25 register stages before it is visible (5 front, one
// middle queue slot, 18 root, one output slot).
// throughput is one request per cycle while full stays low; the root unit
// is an input register and a 17 stage pipeline resolving one result bit
// per stage, and the front multipliers are each followed by a register.
// the front fills an 8 entry middle queue on credit, the root pipeline
// drains it while the 32 entry output queue has room.
// when the receiver stalls the output queue fills, the root pipeline stops
// drawing jobs, then the middle queue fills and full goes high.
// a synchronous reset empties both queues and all pipelines; no clearing pass
module point_to_segment_distance (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic signed [psd_pkg::COORD_W-1:0] in_start_x,
  input  logic signed [psd_pkg::COORD_W-1:0] in_start_y,
  input  logic signed [psd_pkg::COORD_W-1:0] in_end_x,
  input  logic signed [psd_pkg::COORD_W-1:0] in_end_y,
  input  logic signed [psd_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [psd_pkg::COORD_W-1:0] in_point_y,
  output logic                               empty,
  input  logic                               pop,
  output logic [psd_pkg::DIST_W-1:0]         out_seg_distance,
  output logic [1:0]                         out_nearest_part
);

  logic           in_acc, front_v, root_v, mid_pop, out_acc;
  psd_pkg::work_t front_w;
  psd_pkg::res_t  root_r;

  logic [psd_pkg::MID_AW:0]   mid_credit_r, mid_cnt_r;
  logic [psd_pkg::MID_AW-1:0] mid_wp_r, mid_rp_r;
  psd_pkg::work_t             mid_q_r [psd_pkg::MID_DEPTH];

  logic [psd_pkg::OUT_AW:0]   out_credit_r, out_cnt_r;
  logic [psd_pkg::OUT_AW-1:0] out_wp_r, out_rp_r;
  psd_pkg::res_t              out_q_r [psd_pkg::OUT_DEPTH];

  assign full    = mid_credit_r == (psd_pkg::MID_AW + 1)'(psd_pkg::MID_DEPTH);
  assign in_acc  = push && !full;
  assign mid_pop = (mid_cnt_r != '0) &&
                   (out_credit_r != (psd_pkg::OUT_AW + 1)'(psd_pkg::OUT_DEPTH));
  assign empty   = out_cnt_r == '0;
  assign out_acc = pop && !empty;

  psd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_acc),
    .start_x   (in_start_x),
    .start_y   (in_start_y),
    .end_x     (in_end_x),
    .end_y     (in_end_y),
    .point_x   (in_point_x),
    .point_y   (in_point_y),
    .out_valid (front_v),
    .out_work  (front_w)
  );

  psd_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_pop),
    .in_work   (mid_q_r[mid_rp_r]),
    .out_valid (root_v),
    .out_res   (root_r)
  );

  // middle queue and its credit count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_credit_r <= '0;
      mid_cnt_r    <= '0;
      mid_wp_r     <= '0;
      mid_rp_r     <= '0;
    end else begin
      mid_credit_r <= mid_credit_r + (psd_pkg::MID_AW + 1)'(in_acc)
                                   - (psd_pkg::MID_AW + 1)'(mid_pop);
      mid_cnt_r    <= mid_cnt_r + (psd_pkg::MID_AW + 1)'(front_v)
                                - (psd_pkg::MID_AW + 1)'(mid_pop);
      if (front_v) begin
        mid_wp_r <= mid_wp_r + 1'b1;
      end
      if (mid_pop) begin
        mid_rp_r <= mid_rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (front_v) begin
      mid_q_r[mid_wp_r] <= front_w;
    end
  end

  // output queue and its credit count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_credit_r <= '0;
      out_cnt_r    <= '0;
      out_wp_r     <= '0;
      out_rp_r     <= '0;
    end else begin
      out_credit_r <= out_credit_r + (psd_pkg::OUT_AW + 1)'(mid_pop)
                                   - (psd_pkg::OUT_AW + 1)'(out_acc);
      out_cnt_r    <= out_cnt_r + (psd_pkg::OUT_AW + 1)'(root_v)
                                - (psd_pkg::OUT_AW + 1)'(out_acc);
      if (root_v) begin
        out_wp_r <= out_wp_r + 1'b1;
      end
      if (out_acc) begin
        out_rp_r <= out_rp_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (root_v) begin
      out_q_r[out_wp_r] <= root_r;
    end
  end

  assign out_seg_distance = out_q_r[out_rp_r].seg_dist;
  assign out_nearest_part = out_q_r[out_rp_r].part;

endmodule
